/* src/sle_pkg.sv */
`default_nettype none

package sle_pkg;

  // Default store depth.
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths of the request and response transactions.
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned CNT_W  = 7;

  // Request function codes. Code 7 has no meaning and fails with no change.
  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 3'd0,
    FN_APPEND  = 3'd1,
    FN_INSERT  = 3'd2,
    FN_GET     = 3'd3,
    FN_LOCATE  = 3'd4,
    FN_DELETE  = 3'd5,
    FN_REVERSE = 3'd6
  } func_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_GET,
    ST_SCAN,
    ST_COMPACT,
    ST_SHIFT,
    ST_PLACE,
    ST_REV_RD_HI,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_DONE
  } seq_state_t;

  // One request as the sequencer sees it.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  elem_value;
  } req_t;

  // One response.
  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  read_value;
    logic [CNT_W-1:0]  found_index;
    logic [CNT_W-1:0]  list_count;
    logic              is_empty;
  } result_t;

  // Status from the sequencer to the handshake logic.
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

`default_nettype wire

/* src/sle_if.sv */
`default_nettype none

// Request channel: one list operation per transaction.
interface sle_req_if import sle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  elem_value;

  modport source (output valid, output func, output position, output elem_value,
                  input ready);
  modport sink   (input valid, input func, input position, input elem_value,
                  output ready);
endinterface

// Response channel: one result per request.
interface sle_rsp_if import sle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [VAL_W-1:0]  read_value;
  logic [CNT_W-1:0]  found_index;
  logic [CNT_W-1:0]  list_count;
  logic              is_empty;

  modport source (output valid, output ok, output read_value, output found_index,
                  output list_count, output is_empty, input ready);
  modport sink   (input valid, input ok, input read_value, input found_index,
                  input list_count, input is_empty, output ready);
endinterface

`default_nettype wire

/* src/sle_ram.sv */
`default_nettype none

module sle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/sle_seq.sv */
`default_nettype none

module sle_seq import sle_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned LW = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire req_t             req,
  input  wire logic             slot_free,
  output seq_stat_t             stat,
  output result_t               res,
  output logic                  mem_we,
  output logic      [AW-1:0]    mem_waddr,
  output logic      [VAL_W-1:0] mem_wdata,
  output logic      [AW-1:0]    mem_raddr,
  input  wire logic [VAL_W-1:0] mem_rdata
);

  // Width that holds both a position and a length plus one.
  localparam int unsigned XW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  seq_state_t       state, state_next;
  func_t            op, op_next;
  logic [POS_W-1:0] pos_r, pos_r_next;
  logic [VAL_W-1:0] val_r, val_r_next;
  logic [LW-1:0]    len, len_next;
  logic [AW-1:0]    ci, ci_next;
  logic [LW-1:0]    wk, wk_next;
  logic [AW-1:0]    lo, lo_next;
  logic [AW-1:0]    hi, hi_next;
  logic [VAL_W-1:0] hold, hold_next;
  logic             ok_r, ok_r_next;
  logic [VAL_W-1:0] rd_r, rd_r_next;
  logic [CNT_W-1:0] found_r, found_r_next;

  logic [XW-1:0]    len_x, pos_x;
  logic             get_ok, ins_ok, ins_tail, room;
  logic [LW-1:0]    ci_inc, len_m1;
  logic [POS_W-1:0] pos_m1;
  logic [AW-1:0]    pos_a;
  logic             last, hit, rev_more;

  // Position checks and walk bookkeeping.
  always_comb begin
    len_x    = XW'(len);
    pos_x    = XW'(pos_r);
    room     = len < CAP_L;
    get_ok   = (pos_r != '0) && (pos_x <= len_x);
    ins_ok   = room && (pos_r != '0) && (pos_x <= len_x + XW'(1));
    ins_tail = pos_x == len_x + XW'(1);
    ci_inc   = LW'(ci) + LW'(1);
    len_m1   = len - LW'(1);
    pos_m1   = pos_r - POS_W'(1);
    pos_a    = AW'(pos_m1);
    last     = ci_inc == len;
    hit      = mem_rdata == val_r;
    rev_more = ((AW + 1)'(lo) + (AW + 1)'(2)) < (AW + 1)'(hi);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        case (op)
          FN_CLEAR:   state_next = ST_DONE;
          FN_APPEND:  state_next = ST_DONE;
          FN_GET:     state_next = get_ok ? ST_GET : ST_DONE;
          FN_LOCATE:  state_next = (len == '0) ? ST_DONE : ST_SCAN;
          FN_DELETE:  state_next = (len == '0) ? ST_DONE : ST_COMPACT;
          FN_INSERT: begin
            if (!ins_ok) begin
              state_next = ST_DONE;
            end else if (ins_tail) begin
              state_next = ST_PLACE;
            end else begin
              state_next = ST_SHIFT;
            end
          end
          FN_REVERSE: state_next = (len < LW'(2)) ? ST_DONE : ST_REV_RD_HI;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_GET:       state_next = ST_DONE;
      ST_SCAN:      state_next = (hit || last) ? ST_DONE : ST_SCAN;
      ST_COMPACT:   state_next = last ? ST_DONE : ST_COMPACT;
      ST_SHIFT:     state_next = (ci == pos_a) ? ST_PLACE : ST_SHIFT;
      ST_PLACE:     state_next = ST_DONE;
      ST_REV_RD_HI: state_next = ST_REV_WR_LO;
      ST_REV_WR_LO: state_next = ST_REV_WR_HI;
      ST_REV_WR_HI: state_next = rev_more ? ST_REV_RD_HI : ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Memory port control and status. Each read is issued in the cycle before
  // the element that it fetches is compared or moved.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = val_r;
    mem_raddr = '0;
    stat.idle = state == ST_IDLE;
    stat.done = (state == ST_DONE) && slot_free;
    case (state)
      ST_START: begin
        case (op)
          FN_APPEND: begin
            mem_we    = room;
            mem_waddr = len[AW-1:0];
          end
          FN_GET:    mem_raddr = pos_a;
          FN_INSERT: mem_raddr = len_m1[AW-1:0];
          default:   mem_raddr = '0;
        endcase
      end
      ST_SCAN: begin
        mem_raddr = ci_inc[AW-1:0];
      end
      ST_COMPACT: begin
        mem_raddr = ci_inc[AW-1:0];
        mem_we    = !hit;
        mem_waddr = wk[AW-1:0];
        mem_wdata = mem_rdata;
      end
      ST_SHIFT: begin
        mem_raddr = ci - AW'(1);
        mem_we    = 1'b1;
        mem_waddr = ci_inc[AW-1:0];
        mem_wdata = mem_rdata;
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_a;
      end
      ST_REV_RD_HI: begin
        mem_raddr = hi;
      end
      ST_REV_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = mem_rdata;
      end
      ST_REV_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi;
        mem_wdata = hold;
        mem_raddr = lo + AW'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    op_next      = op;
    pos_r_next   = pos_r;
    val_r_next   = val_r;
    len_next     = len;
    ci_next      = ci;
    wk_next      = wk;
    lo_next      = lo;
    hi_next      = hi;
    hold_next    = hold;
    ok_r_next    = ok_r;
    rd_r_next    = rd_r;
    found_r_next = found_r;
    case (state)
      ST_IDLE: begin
        if (start) begin
          op_next      = func_t'(req.func);
          pos_r_next   = req.position;
          val_r_next   = req.elem_value;
          ok_r_next    = 1'b0;
          rd_r_next    = '0;
          found_r_next = '0;
        end
      end
      ST_START: begin
        case (op)
          FN_CLEAR: begin
            len_next  = '0;
            ok_r_next = 1'b1;
          end
          FN_APPEND: begin
            if (room) begin
              len_next  = len + LW'(1);
              ok_r_next = 1'b1;
            end
          end
          FN_LOCATE: begin
            ok_r_next = 1'b1;
            ci_next   = '0;
          end
          FN_DELETE: begin
            ok_r_next = 1'b1;
            ci_next   = '0;
            wk_next   = '0;
          end
          FN_INSERT: begin
            ci_next = len_m1[AW-1:0];
          end
          FN_REVERSE: begin
            ok_r_next = 1'b1;
            lo_next   = '0;
            hi_next   = len_m1[AW-1:0];
          end
          default: begin
            ok_r_next = ok_r;
          end
        endcase
      end
      ST_GET: begin
        ok_r_next = 1'b1;
        rd_r_next = mem_rdata;
      end
      ST_SCAN: begin
        if (hit) begin
          found_r_next = CNT_W'(ci_inc);
        end else if (!last) begin
          ci_next = ci_inc[AW-1:0];
        end
      end
      ST_COMPACT: begin
        if (!hit) begin
          wk_next = wk + LW'(1);
        end
        if (last) begin
          len_next = hit ? wk : wk + LW'(1);
        end else begin
          ci_next = ci_inc[AW-1:0];
        end
      end
      ST_SHIFT: begin
        ci_next = ci - AW'(1);
      end
      ST_PLACE: begin
        len_next  = len + LW'(1);
        ok_r_next = 1'b1;
      end
      ST_REV_RD_HI: begin
        hold_next = mem_rdata;
      end
      ST_REV_WR_HI: begin
        lo_next = lo + AW'(1);
        hi_next = hi - AW'(1);
      end
      default: begin
        hold_next = hold;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
    op      <= op_next;
    pos_r   <= pos_r_next;
    val_r   <= val_r_next;
    ci      <= ci_next;
    wk      <= wk_next;
    lo      <= lo_next;
    hi      <= hi_next;
    hold    <= hold_next;
    ok_r    <= ok_r_next;
    rd_r    <= rd_r_next;
    found_r <= found_r_next;
  end

  // Result as seen after the operation.
  always_comb begin
    res.ok          = ok_r;
    res.read_value  = rd_r;
    res.found_index = found_r;
    res.list_count  = CNT_W'(len);
    res.is_empty    = len == '0;
  end

  a_len_cap: assert property (@(posedge clk) disable iff (rst) len <= CAP_L)
    else $error("list length exceeds the store capacity");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != ST_IDLE && state != ST_DONE))
    else $error("store written while no operation is in progress");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after a result");

  a_shift_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT || state == ST_PLACE) |-> len < CAP_L)
    else $error("insert moving elements in a full store");

endmodule

`default_nettype wire

/* src/sequential_list_engine_core.sv */
// Sequential list engine: an ordered list of bytes in a single store, with a
// length count.
// Request channel (req): func, position and elem_value. Functions are clear,
// append, insert at a 1-based position, get, locate the first equal value,
// delete every equal value, and reverse. Code 7 fails with no change.
// Response channel (rsp): exactly one transaction per request, in order, with
// ok, read_value, found_index, list_count and is_empty.
// Locate, delete, insert and reverse walk the list through the single read and
// single write port of the element store: at most one element read and one
// written per cycle.
// One request is processed at a time; req.ready is high while the sequencer is
// idle, so a request is taken only after the previous result is registered.
// Reset clears the length, so the list starts empty; the store itself is not
// cleared, and the contents of an unwritten entry are never used.
// A result waits in the response register while rsp.ready is low. The next
// request is still accepted and processed, but its result is held back until
// the register frees up.

`default_nettype none

module sequential_list_engine_core import sle_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sle_req_if.sink    req,
  sle_rsp_if.source  rsp
);

  localparam int unsigned AW = $clog2(CAPACITY);

  seq_stat_t        stat;
  result_t          res;
  result_t          rsp_q;
  req_t             req_data;
  logic             rsp_valid;
  logic             start;
  logic             slot_free;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  // Request handshake.
  assign req.ready           = stat.idle;
  assign start               = req.valid && req.ready;
  assign req_data.func       = req.func;
  assign req_data.position   = req.position;
  assign req_data.elem_value = req.elem_value;

  // The response register may be loaded when empty or being emptied.
  assign slot_free = !rsp_valid || rsp.ready;

  sle_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req_data),
    .slot_free (slot_free),
    .stat      (stat),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (stat.done) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_q.ok;
  assign rsp.read_value  = rsp_q.read_value;
  assign rsp.found_index = rsp_q.found_index;
  assign rsp.list_count  = rsp_q.list_count;
  assign rsp.is_empty    = rsp_q.is_empty;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !req.ready)
    else $error("request accepted while an operation is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(stat.done && rsp_valid && !rsp.ready))
    else $error("pending response overwritten");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(stat.done))
    else $error("response raised without a finished operation");

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
  import sle_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  // Function code 7 carries no operation and must fail without any change.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  // One row of the directed stimulus, with an optional hand-written result.
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  elem_value;
    bit                typed;
    result_t           want;
  } dir_row_t;

  logic clk;
  logic rst;

  sle_req_if req ();
  sle_rsp_if rsp ();

  sequential_list_engine_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shadow copy of the list, updated as each request transaction is accepted.
  logic [VAL_W-1:0] list_mem [CAP];
  int               list_len;

  // Results still owed by the block, oldest first.
  result_t pending_results [$];
  int      mismatch_cnt;

  // Hand-written result that travels with the request currently on the bus.
  bit      req_typed;
  result_t req_want;

  // Stimulus shaping.
  bit               steady_send;
  logic [VAL_W-1:0] value_pool [4];

  dir_row_t dir_tab [25];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the shadow list and return the result it must give.
  function automatic result_t list_apply(logic [FUNC_W-1:0] fcode, logic [POS_W-1:0] pos,
                                         logic [VAL_W-1:0] val);
    result_t          r;
    int               n;
    int               k;
    int               p;
    logic [VAL_W-1:0] t;
    r = '0;
    n = list_len;
    p = int'(pos);
    case (func_t'(fcode))
      FN_CLEAR: begin
        n = 0;
        r.ok = 1'b1;
      end
      FN_APPEND: begin
        if (n < CAP) begin
          list_mem[n] = val;
          n++;
          r.ok = 1'b1;
        end
      end
      FN_INSERT: begin
        // Later elements move up by one; position n+1 simply appends.
        if (n < CAP && p >= 1 && p <= n + 1) begin
          for (int i = n; i > p - 1; i--) list_mem[i] = list_mem[i - 1];
          list_mem[p - 1] = val;
          n++;
          r.ok = 1'b1;
        end
      end
      FN_GET: begin
        if (p >= 1 && p <= n) begin
          r.read_value = list_mem[p - 1];
          r.ok = 1'b1;
        end
      end
      FN_LOCATE: begin
        r.ok = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (r.found_index == '0 && list_mem[i] == val) r.found_index = CNT_W'(i + 1);
        end
      end
      FN_DELETE: begin
        // Keep every element that differs, packed toward the front.
        k = 0;
        for (int i = 0; i < n; i++) begin
          if (list_mem[i] != val) begin
            list_mem[k] = list_mem[i];
            k++;
          end
        end
        n = k;
        r.ok = 1'b1;
      end
      FN_REVERSE: begin
        for (int i = 0; i < n / 2; i++) begin
          t = list_mem[i];
          list_mem[i] = list_mem[n - 1 - i];
          list_mem[n - 1 - i] = t;
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    list_len = n;
    r.list_count = CNT_W'(n);
    r.is_empty = (n == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Predict on every accepted request; compare every accepted response.
  always @(posedge clk) begin
    result_t pred;
    result_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        pred = list_apply(req.func, req.position, req.elem_value);
        pending_results.push_back(req_typed ? req_want : pred);
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("ok", 8'(want.ok), 8'(rsp.ok));
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("found_index", 8'(want.found_index), 8'(rsp.found_index));
          check_field("list_count", 8'(want.list_count), 8'(rsp.list_count));
          check_field("is_empty", 8'(want.is_empty), 8'(rsp.is_empty));
        end
      end
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Position near the valid range [1, hi], with the edges and junk mixed in.
  function automatic logic [POS_W-1:0] pick_pos(int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return POS_W'((hi >= 1) ? $urandom_range(1, hi) : 1);
    if (r < 86) return '0;
    if (r < 93) return POS_W'(hi + 1);
    return POS_W'($urandom_range(0, 127));
  endfunction

  function automatic dir_row_t mk(logic [FUNC_W-1:0] f, int p, int v, bit typed = 1'b0,
                                  bit ok = 1'b0, int rd = 0, int fi = 0, int cnt = 0);
    dir_row_t row;
    row.func = f;
    row.position = POS_W'(p);
    row.elem_value = VAL_W'(v);
    row.typed = typed;
    row.want.ok = ok;
    row.want.read_value = VAL_W'(rd);
    row.want.found_index = CNT_W'(fi);
    row.want.list_count = CNT_W'(cnt);
    row.want.is_empty = (cnt == 0);
    return row;
  endfunction

  // Hold one request on the bus until the block takes it.
  task automatic push_req(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p, logic [VAL_W-1:0] v,
                          bit typed = 1'b0, result_t want = '0);
    int g;
    g = steady_send ? 0 : gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.position <= p;
    req.elem_value <= v;
    req_typed <= typed;
    req_want <= want;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic wait_results_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Append until the store is full, then try to grow it past capacity.
  task automatic fill_to_capacity();
    while (list_len < CAP) push_req(FN_APPEND, POS_W'($urandom), VAL_W'($urandom));
    push_req(FN_APPEND, POS_W'($urandom), VAL_W'($urandom));
    push_req(FN_INSERT, POS_W'($urandom_range(1, CAP + 1)), VAL_W'($urandom));
    push_req(FN_INSERT, POS_W'(CAP + 1), VAL_W'($urandom));
  endtask

  // One random request, weighted toward operations that keep the list busy.
  task automatic random_request();
    int               r;
    int               n;
    logic [VAL_W-1:0] v;
    n = list_len;
    v = ($urandom_range(0, 9) < 6) ? value_pool[$urandom_range(0, 3)] : VAL_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 30)      push_req(FN_APPEND, POS_W'($urandom), v);
    else if (r < 50) push_req(FN_INSERT, pick_pos(n + 1), v);
    else if (r < 63) push_req(FN_GET, pick_pos(n), v);
    else if (r < 73) push_req(FN_LOCATE, POS_W'($urandom), v);
    else if (r < 80) push_req(FN_DELETE, POS_W'($urandom), v);
    else if (r < 88) push_req(FN_REVERSE, POS_W'($urandom), v);
    else if (r < 89) push_req(FN_CLEAR, POS_W'($urandom), v);
    else if (r < 91) push_req(FN_UNUSED, POS_W'($urandom), v);
    else             push_req(FUNC_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic drive_rsp_ready(bit lvl, int cyc);
    rsp.ready <= lvl;
    repeat (cyc) @(posedge clk);
  endtask

  // Response side: long open stretches alternate with bursts of stalls.
  initial begin
    int g;
    rsp.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        drive_rsp_ready(1'b1, $urandom_range(20, 200));
      end else begin
        repeat ($urandom_range(1, 12)) begin
          g = gap_len();
          if (g > 0) drive_rsp_ready(1'b0, g);
          drive_rsp_ready(1'b1, $urandom_range(1, 4));
        end
      end
    end
  end

  // Main stimulus: reset, directed table, then random traffic.
  initial begin
    int i;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.func <= FN_CLEAR;
    req.position <= '0;
    req.elem_value <= '0;
    req_typed <= 1'b0;
    req_want <= '0;
    list_len = 0;
    mismatch_cnt = 0;
    steady_send = 1'b0;
    foreach (value_pool[j]) value_pool[j] = VAL_W'($urandom);

    // Empty list, boundary positions, and the failure and no-match cases.
    dir_tab = '{
      mk(FN_GET,      1,   8'h00, 1, 0, 0,     0, 0),
      mk(FN_REVERSE,  0,   8'h00, 1, 1, 0,     0, 0),
      mk(FN_LOCATE,   0,   8'h00, 1, 1, 0,     0, 0),
      mk(FN_DELETE,   0,   8'h00, 1, 1, 0,     0, 0),
      mk(FN_INSERT,   0,   8'hFF, 1, 0, 0,     0, 0),
      mk(FN_INSERT,   2,   8'hFF, 1, 0, 0,     0, 0),
      mk(FN_INSERT,   1,   8'hFF, 1, 1, 0,     0, 1),
      mk(FN_REVERSE,  0,   8'h00, 1, 1, 0,     0, 1),
      mk(FN_GET,      1,   8'h00, 1, 1, 8'hFF, 0, 1),
      mk(FN_APPEND,   127, 8'h00, 1, 1, 0,     0, 2),
      mk(FN_APPEND,   0,   8'hA5, 1, 1, 0,     0, 3),
      mk(FN_INSERT,   4,   8'h5A, 1, 1, 0,     0, 4),
      mk(FN_INSERT,   2,   8'h80),
      mk(FN_GET,      5,   8'h00),
      mk(FN_GET,      6,   8'h00, 1, 0, 0,     0, 5),
      mk(FN_GET,      127, 8'hFF, 1, 0, 0,     0, 5),
      mk(FN_LOCATE,   0,   8'hA5),
      mk(FN_LOCATE,   0,   8'h33, 1, 1, 0,     0, 5),
      mk(FN_REVERSE,  0,   8'h00),
      mk(FN_GET,      1,   8'h00),
      mk(FN_DELETE,   0,   8'h33, 1, 1, 0,     0, 5),
      mk(FN_DELETE,   0,   8'hFF),
      mk(FN_UNUSED,   127, 8'hFF),
      mk(FN_CLEAR,    127, 8'hFF, 1, 1, 0,     0, 0),
      mk(FN_UNUSED,   0,   8'h00, 1, 0, 0,     0, 0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[j]) begin
      push_req(dir_tab[j].func, dir_tab[j].position, dir_tab[j].elem_value,
               dir_tab[j].typed, dir_tab[j].want);
    end

    for (i = 0; i < 1500; i++) begin
      // Every so often let the block run dry, and now and then fill it up.
      if (i % 350 == 0) begin
        wait_results_drained();
        fill_to_capacity();
      end else if (i % 125 == 0) begin
        wait_results_drained();
      end
      if (i % 200 == 0) begin
        foreach (value_pool[j]) begin
          value_pool[j] = ($urandom_range(0, 9) < 2) ? {VAL_W{$urandom_range(0, 1) == 1}}
                                                     : VAL_W'($urandom);
        end
      end
      if (i % 64 == 0) steady_send = ($urandom_range(0, 3) == 0);
      random_request();
    end

    wait_results_drained();
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
